// File: rtl/core/mntc_pkg.sv
package mntc_pkg;

  localparam int NOTE_COUNT = 128;
  localparam int CLK_W      = 26;
  localparam int FREQ_W     = 16;
  localparam int ROM_W      = 14;

  localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;
  localparam logic [3:0] MIDI_NOTE_ON  = 4'h9;
  localparam logic [3:0] MIDI_CTRL     = 4'hB;

  localparam logic [7:0] CC_SOUND_OFF  = 8'd120;
  localparam logic [7:0] CC_NOTES_OFF  = 8'd123;
  localparam logic [7:0] NO_NOTE       = 8'hFF;

  localparam logic [1:0] REG_TIMER_CLK = 2'd0;
  localparam logic [1:0] REG_MIN_TONE  = 2'd1;
  localparam logic [1:0] REG_MAX_TONE  = 2'd2;

  localparam logic [CLK_W-1:0]  RST_TIMER_CLK = CLK_W'(1000000);
  localparam logic [FREQ_W-1:0] RST_MIN_TONE  = FREQ_W'(20);
  localparam logic [FREQ_W-1:0] RST_MAX_TONE  = FREQ_W'(8000);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN,
    ST_RESP
  } state_t;

  localparam logic [ROM_W-1:0] NOTE_FREQ [NOTE_COUNT] = '{
    14'd8, 14'd9, 14'd9, 14'd10, 14'd10, 14'd11, 14'd12, 14'd12, 14'd13, 14'd14, 14'd15,
    14'd15, 14'd16, 14'd17, 14'd18, 14'd19, 14'd21, 14'd22, 14'd23, 14'd24, 14'd26, 14'd28,
    14'd29, 14'd31, 14'd33, 14'd35, 14'd37, 14'd39, 14'd41, 14'd44, 14'd46, 14'd49, 14'd52,
    14'd55, 14'd58, 14'd62, 14'd65, 14'd69, 14'd73, 14'd78, 14'd82, 14'd87, 14'd92, 14'd98,
    14'd104, 14'd110, 14'd117, 14'd123, 14'd131, 14'd139, 14'd147, 14'd156, 14'd165,
    14'd175, 14'd185, 14'd196, 14'd208, 14'd220, 14'd233, 14'd247, 14'd262, 14'd277,
    14'd294, 14'd311, 14'd330, 14'd349, 14'd370, 14'd392, 14'd415, 14'd440, 14'd466,
    14'd494, 14'd523, 14'd554, 14'd587, 14'd622, 14'd659, 14'd698, 14'd740, 14'd784,
    14'd831, 14'd880, 14'd932, 14'd988, 14'd1047, 14'd1109, 14'd1175, 14'd1245, 14'd1319,
    14'd1397, 14'd1480, 14'd1568, 14'd1661, 14'd1760, 14'd1865, 14'd1976, 14'd2093,
    14'd2217, 14'd2349, 14'd2489, 14'd2637, 14'd2794, 14'd2960, 14'd3136, 14'd3322,
    14'd3520, 14'd3729, 14'd3951, 14'd4186, 14'd4435, 14'd4699, 14'd4978, 14'd5274,
    14'd5588, 14'd5920, 14'd6272, 14'd6645, 14'd7040, 14'd7459, 14'd7902, 14'd8372,
    14'd8870, 14'd9397, 14'd9956, 14'd10548, 14'd11175, 14'd11840, 14'd12544
  };

endpackage

// File: rtl/core/midi_note_tone_controller.sv
// MIDI note to square-wave tone timer settings.
// Input channel: one MIDI channel message per transfer (in_status_byte,
// in_data_one, in_data_two), taken when in_valid is high and in_stall low.
// Output channel: exactly one result per message (tone state, reload and
// compare values, sounding note), taken when out_valid is high and out_stall low.
// Config channel: cfg_index 0 timer clock, 1 min tone, 2 max tone; cfg_ready is
// always high. Write only while the block is idle.
// Flow: a note on runs the 26-step bit-serial divider computing clock /
// frequency before its result; a note on whose clamped frequency is zero skips
// the divider; other messages go straight to the result.
// One message is in work at a time; in_stall stays high until its result enters the output register.
// The output register holds a result while out_stall is high; the next message
// may be accepted meanwhile, its result waits until the register is taken.
// Reset: no note held, reload 65535, compare 0, registers at 1 MHz, 20 Hz,
// 8000 Hz, output empty.
module midi_note_tone_controller
  import mntc_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_status_byte,
  input  logic [7:0]        in_data_one,
  input  logic [7:0]        in_data_two,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_tone_on,
  output logic [15:0]       out_reload_value,
  output logic [15:0]       out_compare_value,
  output logic [7:0]        out_sounding_note,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [CLK_W-1:0]  cfg_data
);

  localparam int EW = (TIMER_BITS > CLK_W) ? TIMER_BITS : CLK_W;
  localparam logic [EW-1:0] TMAX_EXT = EW'({TIMER_BITS{1'b1}});

  state_t state_r, state_nxt;

  logic [CLK_W-1:0]      clk_hz_r;
  logic [FREQ_W-1:0]     min_r, max_r;
  logic [7:0]            held_r, held_nxt;
  logic [6:0]            note_r, note_nxt;
  logic                  fzero_r, fzero_nxt;
  logic [TIMER_BITS-1:0] period_r, period_nxt;
  logic [TIMER_BITS-1:0] duty_r, duty_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_tone_r, out_tone_nxt;
  logic [15:0]           out_reload_r, out_reload_nxt;
  logic [15:0]           out_cmp_r, out_cmp_nxt;
  logic [7:0]            out_note_r, out_note_nxt;

  logic                  in_fire;
  logic [FREQ_W-1:0]     f_lo, f_clamp;
  logic                  div_start, div_done;
  logic [CLK_W-1:0]      div_q;
  logic [CLK_W-1:0]      q_m1;
  logic [EW-1:0]         q_ext, rel_ext;
  logic [TIMER_BITS-1:0] reload;
  logic [TIMER_BITS:0]   reload_p1;
  logic                  release_hit;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= RST_TIMER_CLK;
      min_r    <= RST_MIN_TONE;
      max_r    <= RST_MAX_TONE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TIMER_CLK: clk_hz_r <= cfg_data;
        REG_MIN_TONE:  min_r    <= cfg_data[FREQ_W-1:0];
        REG_MAX_TONE:  max_r    <= cfg_data[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp: ceiling applied last
  always_comb begin
    f_lo    = FREQ_W'(NOTE_FREQ[in_data_one[6:0]]);
    if (f_lo < min_r) f_lo = min_r;
    f_clamp = (f_lo > max_r) ? max_r : f_lo;
  end

  mntc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (clk_hz_r),
    .divisor  (f_clamp),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    q_m1      = (div_q == '0) ? '0 : div_q - 1'b1;
    q_ext     = EW'(q_m1);
    rel_ext   = fzero_r ? TMAX_EXT : ((q_ext > TMAX_EXT) ? TMAX_EXT : q_ext);
    reload    = rel_ext[TIMER_BITS-1:0];
    reload_p1 = {1'b0, reload} + 1'b1;
  end

  assign release_hit = (in_data_one == held_r) || (in_data_one == NO_NOTE);

  always_comb begin
    state_nxt      = state_r;
    held_nxt       = held_r;
    note_nxt       = note_r;
    fzero_nxt      = fzero_r;
    period_nxt     = period_r;
    duty_nxt       = duty_r;
    div_start      = 1'b0;
    out_valid_nxt  = out_valid_r && out_stall;
    out_tone_nxt   = out_tone_r;
    out_reload_nxt = out_reload_r;
    out_cmp_nxt    = out_cmp_r;
    out_note_nxt   = out_note_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_RESP;
          case (in_status_byte[7:4])
            MIDI_NOTE_ON: begin
              if (in_data_two != 8'd0) begin
                if (!in_data_one[7]) begin
                  note_nxt  = in_data_one[6:0];
                  fzero_nxt = (f_clamp == '0);
                  if (f_clamp == '0) begin
                    state_nxt = ST_FIN;
                  end else begin
                    div_start = 1'b1;
                    state_nxt = ST_DIV;
                  end
                end
              end else if (release_hit) begin
                held_nxt = NO_NOTE;
              end
            end
            MIDI_NOTE_OFF: begin
              if (release_hit) held_nxt = NO_NOTE;
            end
            MIDI_CTRL: begin
              if ((in_data_one == CC_SOUND_OFF) || (in_data_one == CC_NOTES_OFF)) begin
                held_nxt = NO_NOTE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        period_nxt = reload;
        duty_nxt   = reload_p1[TIMER_BITS:1];
        held_nxt   = {1'b0, note_r};
        state_nxt  = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_tone_nxt   = (held_r != NO_NOTE);
          out_reload_nxt = period_r[15:0];
          out_cmp_nxt    = duty_r[15:0];
          out_note_nxt   = held_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= NO_NOTE;
      period_r    <= TIMER_BITS'(17'h0FFFF);
      duty_r      <= '0;
      out_valid_r <= 1'b0;
      fzero_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      period_r    <= period_nxt;
      duty_r      <= duty_nxt;
      out_valid_r <= out_valid_nxt;
      fzero_r     <= fzero_nxt;
    end
    note_r       <= note_nxt;
    out_tone_r   <= out_tone_nxt;
    out_reload_r <= out_reload_nxt;
    out_cmp_r    <= out_cmp_nxt;
    out_note_r   <= out_note_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_tone_on       = out_tone_r;
  assign out_reload_value  = out_reload_r;
  assign out_compare_value = out_cmp_r;
  assign out_sounding_note = out_note_r;

endmodule

// File: rtl/core/mntc_div.sv
module mntc_div
  import mntc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CLK_W-1:0]  dividend,
  input  logic [FREQ_W-1:0] divisor,
  output logic              done,
  output logic [CLK_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(CLK_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(CLK_W - 1);

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [FREQ_W-1:0] rem_r, rem_nxt;
  logic [FREQ_W-1:0] dvs_r, dvs_nxt;
  logic [CLK_W-1:0]  quo_r, quo_nxt;
  logic [FREQ_W:0]   trial;
  logic              fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial    = {rem_r, quo_r[CLK_W-1]};
    fits     = trial >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? FREQ_W'(trial - {1'b0, dvs_r}) : trial[FREQ_W-1:0];
      quo_nxt = {quo_r[CLK_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = busy_r && (cnt_r == LAST);
  assign quotient = quo_r;

endmodule
